/* design/rgbkf_pkg.sv */
// Shared types and constants for the RGB 3x3 kernel filter.
// No dependencies; used by every design file except rgbkf_ram.
package rgbkf_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int MIN_SIDE   = 3;
  localparam int SIDE_RESET = 1024;
  localparam int CNT_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = 11;
  localparam int COORD_W    = 10;

  localparam int CH_W    = 8;
  localparam int NCH     = 3;
  localparam int INT_W   = CH_W + 2;
  localparam int SUM_W   = CH_W + 4;
  localparam int PRE_W   = SUM_W + 2;
  localparam int CH_MAX  = 255;

  localparam int WIN_N     = 9;
  localparam int WIN_IDX_W = $clog2(WIN_N);
  localparam int WIN_CTR   = 4;

  // floor(x/d) == (x*RECIP) >> RECIP_SH for every x below 2^SUM_W
  localparam int RECIP_SH = 16;
  localparam int RECIP9   = (1 << RECIP_SH) / 9 + 1;
  localparam int RECIP7   = (1 << RECIP_SH) / 7 + 1;
  localparam int MUL_W    = SUM_W + RECIP_SH;
  localparam int QUO_W    = MUL_W - RECIP_SH;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = CFG_IDX_W'(1);

  localparam logic [1:0] MODE_BOX   = 2'd0;
  localparam logic [1:0] MODE_TRIM  = 2'd1;
  localparam logic [1:0] MODE_SHARP = 2'd2;

  // channel 2 red, 1 green, 0 blue
  typedef logic [NCH-1:0][CH_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;

  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
  } out_item_t;

endpackage

/* design/rgbkf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgbkf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/rgbkf_calc.sv */
// Four-stage kernel datapath: intensities and sums, extremum search,
// mode select, reciprocal divide (box and trim) and clamp. Uses rgbkf_pkg.
module rgbkf_calc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  rgbkf_pkg::win_t       win,
  input  rgbkf_pkg::tag_t       tag,
  input  logic [1:0]            mode,
  output logic                  done,
  output rgbkf_pkg::out_item_t  result
);

  // stage A: intensities and channel sums
  logic                                  a_valid_r;
  logic [rgbkf_pkg::INT_W-1:0]           a_int_r [rgbkf_pkg::WIN_N];
  logic [rgbkf_pkg::NCH-1:0][rgbkf_pkg::SUM_W-1:0] a_sum_r;
  rgbkf_pkg::win_t                       a_win_r;
  rgbkf_pkg::tag_t                       a_tag_r;
  logic [rgbkf_pkg::INT_W-1:0]           int_nxt [rgbkf_pkg::WIN_N];
  logic [rgbkf_pkg::NCH-1:0][rgbkf_pkg::SUM_W-1:0] sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < rgbkf_pkg::WIN_N; k++) begin
      int_nxt[k] = rgbkf_pkg::INT_W'(win[k][2]) + rgbkf_pkg::INT_W'(win[k][1])
                 + rgbkf_pkg::INT_W'(win[k][0]);
      for (int c = 0; c < rgbkf_pkg::NCH; c++) begin
        sum_nxt[c] = sum_nxt[c] + rgbkf_pkg::SUM_W'(win[k][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start;
    end
    a_int_r <= int_nxt;
    a_sum_r <= sum_nxt;
    a_win_r <= win;
    a_tag_r <= tag;
  end

  // stage B: lowest (last tie) and highest (first tie) intensity
  logic                              b_valid_r;
  logic [rgbkf_pkg::WIN_IDX_W-1:0]   b_lo_r;
  logic [rgbkf_pkg::WIN_IDX_W-1:0]   b_hi_r;
  logic [rgbkf_pkg::NCH-1:0][rgbkf_pkg::SUM_W-1:0] b_sum_r;
  rgbkf_pkg::win_t                   b_win_r;
  rgbkf_pkg::tag_t                   b_tag_r;
  logic [rgbkf_pkg::WIN_IDX_W-1:0]   lo_nxt;
  logic [rgbkf_pkg::WIN_IDX_W-1:0]   hi_nxt;
  logic [rgbkf_pkg::INT_W-1:0]       lo_val;
  logic [rgbkf_pkg::INT_W-1:0]       hi_val;

  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    lo_val = a_int_r[0];
    hi_val = a_int_r[0];
    for (int k = 1; k < rgbkf_pkg::WIN_N; k++) begin
      if (a_int_r[k] <= lo_val) begin
        lo_val = a_int_r[k];
        lo_nxt = rgbkf_pkg::WIN_IDX_W'(k);
      end
      if (a_int_r[k] > hi_val) begin
        hi_val = a_int_r[k];
        hi_nxt = rgbkf_pkg::WIN_IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_lo_r  <= lo_nxt;
    b_hi_r  <= hi_nxt;
    b_sum_r <= a_sum_r;
    b_win_r <= a_win_r;
    b_tag_r <= a_tag_r;
  end

  // stage C: dividend or sharpened value per channel
  logic                                    c_valid_r;
  logic signed [rgbkf_pkg::PRE_W-1:0]      c_pre_r [rgbkf_pkg::NCH];
  rgbkf_pkg::tag_t                         c_tag_r;
  logic signed [rgbkf_pkg::PRE_W-1:0]      pre_nxt [rgbkf_pkg::NCH];
  rgbkf_pkg::pix_t                         lo_px;
  rgbkf_pkg::pix_t                         hi_px;
  rgbkf_pkg::pix_t                         ctr_px;
  logic [rgbkf_pkg::PRE_W-1:0]             sum_ext;
  logic [rgbkf_pkg::PRE_W-1:0]             ctr_ext;

  always_comb begin
    lo_px  = b_win_r[b_lo_r];
    hi_px  = b_win_r[b_hi_r];
    ctr_px = b_win_r[rgbkf_pkg::WIN_CTR];
    for (int c = 0; c < rgbkf_pkg::NCH; c++) begin
      sum_ext = rgbkf_pkg::PRE_W'(b_sum_r[c]);
      ctr_ext = rgbkf_pkg::PRE_W'(ctr_px[c]);
      case (mode)
        rgbkf_pkg::MODE_TRIM:
          pre_nxt[c] = $signed(sum_ext - rgbkf_pkg::PRE_W'(lo_px[c])
                               - rgbkf_pkg::PRE_W'(hi_px[c]));
        rgbkf_pkg::MODE_SHARP:
          pre_nxt[c] = $signed((ctr_ext << 3) + (ctr_ext << 1) - sum_ext);
        default:
          pre_nxt[c] = $signed(sum_ext);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
    c_pre_r <= pre_nxt;
    c_tag_r <= b_tag_r;
  end

  // stage D: divide by reciprocal (box and trim), clamp
  logic                                   d_valid_r;
  rgbkf_pkg::out_item_t                   d_res_r;
  rgbkf_pkg::pix_t                        chan_nxt;
  logic [rgbkf_pkg::MUL_W-1:0]            prod;
  logic [rgbkf_pkg::QUO_W-1:0]            quo;

  always_comb begin
    chan_nxt = '0;
    prod     = '0;
    quo      = '0;
    for (int c = 0; c < rgbkf_pkg::NCH; c++) begin
      case (mode)
        rgbkf_pkg::MODE_SHARP: begin
          if (c_pre_r[c] < 0) begin
            chan_nxt[c] = '0;
          end else if (c_pre_r[c] > rgbkf_pkg::CH_MAX) begin
            chan_nxt[c] = rgbkf_pkg::CH_W'(rgbkf_pkg::CH_MAX);
          end else begin
            chan_nxt[c] = c_pre_r[c][rgbkf_pkg::CH_W-1:0];
          end
        end
        default: begin
          if (mode == rgbkf_pkg::MODE_TRIM) begin
            prod = rgbkf_pkg::MUL_W'(c_pre_r[c][rgbkf_pkg::SUM_W-1:0])
                 * rgbkf_pkg::MUL_W'(rgbkf_pkg::RECIP7);
          end else begin
            prod = rgbkf_pkg::MUL_W'(c_pre_r[c][rgbkf_pkg::SUM_W-1:0])
                 * rgbkf_pkg::MUL_W'(rgbkf_pkg::RECIP9);
          end
          quo = prod[rgbkf_pkg::MUL_W-1:rgbkf_pkg::RECIP_SH];
          if (quo > rgbkf_pkg::QUO_W'(rgbkf_pkg::CH_MAX)) begin
            chan_nxt[c] = rgbkf_pkg::CH_W'(rgbkf_pkg::CH_MAX);
          end else begin
            chan_nxt[c] = quo[rgbkf_pkg::CH_W-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= c_valid_r;
    end
    d_res_r.out_red   <= chan_nxt[2];
    d_res_r.out_green <= chan_nxt[1];
    d_res_r.out_blue  <= chan_nxt[0];
    d_res_r.pixel_row <= c_tag_r.row;
    d_res_r.pixel_col <= c_tag_r.col;
  end

  assign done   = d_valid_r;
  assign result = d_res_r;

endmodule

/* design/rgb_3x3_kernel_filter.sv */
// Top level of the RGB 3x3 kernel filter: counters, line store, window,
// result queue. Uses rgbkf_pkg, rgbkf_ram and rgbkf_calc.
//
// Takes one pixel per clock in raster order while in_stall is low and returns
// one result per interior pixel, formed through stage 1, the window register
// and the four rgbkf_calc stages. Both previous rows sit in one 48-bit line
// store RAM that is read at the current column when a pixel is taken and
// written back at that column on the next cycle; consecutive pixels always
// hit different columns, so no forwarding is needed. Results wait in a
// 16-entry queue; in_stall rises when 16 results are accepted but not yet
// transferred, so the input keeps full rate as long as out_stall stays low.
// The line store is not cleared after reset; the first two rows of an image
// fill it before any result is formed.
module rgb_3x3_kernel_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rgbkf_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rgbkf_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [rgbkf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgbkf_pkg::SIDE_W-1:0]        cfg_wdata
);

  logic [1:0]                     mode_r;
  logic [rgbkf_pkg::SIDE_W-1:0]   side_r;
  logic [rgbkf_pkg::CNT_W:0]      side_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rgbkf_pkg::MODE_BOX;
      side_r <= rgbkf_pkg::SIDE_W'(rgbkf_pkg::SIDE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgbkf_pkg::CFG_MODE: mode_r <= cfg_wdata[1:0];
        rgbkf_pkg::CFG_SIDE: side_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_r < rgbkf_pkg::SIDE_W'(rgbkf_pkg::MIN_SIDE)) begin
      side_eff = (rgbkf_pkg::CNT_W+1)'(rgbkf_pkg::MIN_SIDE);
    end else if (int'(side_r) > rgbkf_pkg::MAX_SIDE) begin
      side_eff = (rgbkf_pkg::CNT_W+1)'(rgbkf_pkg::MAX_SIDE);
    end else begin
      side_eff = (rgbkf_pkg::CNT_W+1)'(side_r);
    end
  end

  // input side
  logic                          in_xfer;
  logic                          out_xfer;
  logic                          prod;
  logic [rgbkf_pkg::CNT_W-1:0]   col_r;
  logic [rgbkf_pkg::CNT_W-1:0]   row_r;
  logic [rgbkf_pkg::CNT_W:0]     col_inc;
  logic [rgbkf_pkg::CNT_W:0]     row_inc;
  logic [rgbkf_pkg::PTR_W:0]     occ_r;
  logic [rgbkf_pkg::PTR_W:0]     occ_nxt;

  assign in_stall = occ_r >= (rgbkf_pkg::PTR_W+1)'(rgbkf_pkg::FIFO_DEPTH);
  assign in_xfer  = in_valid && !in_stall;
  assign prod     = (row_r >= rgbkf_pkg::CNT_W'(2)) && (col_r >= rgbkf_pkg::CNT_W'(2));
  assign col_inc  = {1'b0, col_r} + (rgbkf_pkg::CNT_W+1)'(1);
  assign row_inc  = {1'b0, row_r} + (rgbkf_pkg::CNT_W+1)'(1);
  assign occ_nxt  = occ_r + (rgbkf_pkg::PTR_W+1)'(in_xfer && prod)
                  - (rgbkf_pkg::PTR_W+1)'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      if (in_xfer) begin
        if (col_inc >= side_eff) begin
          col_r <= '0;
          if (row_inc >= side_eff) begin
            row_r <= '0;
          end else begin
            row_r <= row_inc[rgbkf_pkg::CNT_W-1:0];
          end
        end else begin
          col_r <= col_inc[rgbkf_pkg::CNT_W-1:0];
        end
      end
    end
  end

  // stage 1: line store read data arrives, write back, window shift
  logic                          s1_valid_r;
  logic                          s1_prod_r;
  rgbkf_pkg::pix_t               s1_px_r;
  logic [rgbkf_pkg::CNT_W-1:0]   s1_col_r;
  rgbkf_pkg::tag_t               s1_tag_r;
  rgbkf_pkg::line_t              line_rd;
  rgbkf_pkg::line_t              line_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
    s1_prod_r    <= prod;
    s1_px_r      <= {in_data.in_red, in_data.in_green, in_data.in_blue};
    s1_col_r     <= col_r;
    s1_tag_r.row <= rgbkf_pkg::COORD_W'(row_r - rgbkf_pkg::CNT_W'(1));
    s1_tag_r.col <= rgbkf_pkg::COORD_W'(col_r - rgbkf_pkg::CNT_W'(1));
  end

  assign line_wr.upper  = line_rd.middle;
  assign line_wr.middle = s1_px_r;

  rgbkf_ram #(
    .WIDTH ($bits(rgbkf_pkg::line_t)),
    .DEPTH (rgbkf_pkg::MAX_SIDE)
  ) u_line (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (line_wr),
    .re    (in_xfer),
    .raddr (col_r),
    .rdata (line_rd)
  );

  rgbkf_pkg::win_t  window_r;
  rgbkf_pkg::win_t  window_nxt;
  logic             s2_valid_r;
  rgbkf_pkg::tag_t  s2_tag_r;

  always_comb begin
    window_nxt = window_r;
    if (s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        window_nxt[r*3]   = window_r[r*3+1];
        window_nxt[r*3+1] = window_r[r*3+2];
      end
      window_nxt[2] = line_rd.upper;
      window_nxt[5] = line_rd.middle;
      window_nxt[8] = s1_px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      window_r   <= window_nxt;
      s2_valid_r <= s1_valid_r && s1_prod_r;
    end
    s2_tag_r <= s1_tag_r;
  end

  logic                   calc_done;
  rgbkf_pkg::out_item_t   calc_res;

  rgbkf_calc u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (s2_valid_r),
    .win    (window_r),
    .tag    (s2_tag_r),
    .mode   (mode_r),
    .done   (calc_done),
    .result (calc_res)
  );

  // result queue
  rgbkf_pkg::out_item_t        fifo_r [rgbkf_pkg::FIFO_DEPTH];
  logic [rgbkf_pkg::PTR_W:0]   wr_ptr_r;
  logic [rgbkf_pkg::PTR_W:0]   rd_ptr_r;

  assign out_valid = wr_ptr_r != rd_ptr_r;
  assign out_xfer  = out_valid && !out_stall;
  assign out_data  = fifo_r[rd_ptr_r[rgbkf_pkg::PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (calc_done) begin
        wr_ptr_r <= wr_ptr_r + (rgbkf_pkg::PTR_W+1)'(1);
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + (rgbkf_pkg::PTR_W+1)'(1);
      end
    end
    if (calc_done) begin
      fifo_r[wr_ptr_r[rgbkf_pkg::PTR_W-1:0]] <= calc_res;
    end
  end

endmodule

/* design/rgbkf_checker.sv */
// Port-level checks for rgb_3x3_kernel_filter, bound to the top level.
// Uses rgbkf_pkg.
module rgbkf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input rgbkf_pkg::out_item_t             out_data
);

  // reset empties the queue and reopens the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue not empty or input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // only interior pixels give results
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pixel_row != '0 && out_data.pixel_col != '0
                  && out_data.pixel_row <= rgbkf_pkg::COORD_W'(rgbkf_pkg::MAX_SIDE - 2)
                  && out_data.pixel_col <= rgbkf_pkg::COORD_W'(rgbkf_pkg::MAX_SIDE - 2))
    else $error("result tagged with a border pixel");

  // a cycle with no new input cannot raise the stall
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !in_valid |=> !in_stall)
    else $error("stall rose without an input transfer");

endmodule

bind rgb_3x3_kernel_filter rgbkf_checker u_rgbkf_checker (.*);
